FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Whenever ante holds, cons must hold at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/pls_pkg.sv
`default_nettype none
package pls_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned OP_W   = 2;
  // Wide enough for any cell index and for a length of up to 4096.
  localparam int unsigned IDX_W  = 13;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] at;
    logic [IDX_W-1:0] cnt;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/pls_cell.sv
`default_nettype none
module pls_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                      clk,
  input  wire pls_pkg::cell_cmd_t        cmd,
  input  wire logic [pls_pkg::WORD_W-1:0] value,
  input  wire logic [pls_pkg::WORD_W-1:0] left,
  input  wire logic [pls_pkg::WORD_W-1:0] right,
  output logic      [pls_pkg::WORD_W-1:0] entry
);
  import pls_pkg::*;

  localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

  logic [WORD_W-1:0] entry_r;
  logic [WORD_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins && (ME == cmd.at)) begin
      entry_nxt = value;
    end else if (cmd.ins && (ME > cmd.at) && (ME <= cmd.cnt)) begin
      entry_nxt = left;
    end else if (cmd.del && (ME >= cmd.at) && ((ME + IDX_W'(1)) < cmd.cnt)) begin
      entry_nxt = right;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

FILE: rtl/core/pls_rd_group.sv
`default_nettype none
module pls_rd_group #(
  parameter int unsigned N    = 8,
  parameter int unsigned BASE = 0
) (
  input  wire logic                       clk,
  input  wire logic [pls_pkg::WORD_W-1:0] ents [N],
  input  wire logic                       rd_en,
  input  wire logic [pls_pkg::IDX_W-1:0]  at,
  output logic      [pls_pkg::WORD_W-1:0] grp
);
  import pls_pkg::*;

  logic [WORD_W-1:0] grp_r;
  logic [WORD_W-1:0] grp_nxt;

  always_comb begin
    grp_nxt = '0;
    for (int unsigned i = 0; i < N; i++) begin
      if (rd_en && (at == IDX_W'(BASE + i))) begin
        grp_nxt = grp_nxt | ents[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  assign grp = grp_r;

endmodule
`default_nettype wire

FILE: rtl/core/positional_list_store.sv
`default_nettype none
`include "assert_macros.svh"
// Positional list store: an ordered list of up to DEPTH signed 32-bit words.
// A request is presented on in_operation, in_position and in_value with start
// high; it is taken at a rising edge where start is high and busy is low.
// Insert places a word at 1-based position p (1 to length+1) and moves later
// words up; delete removes the word at p (1 to length) and moves later words
// down; read returns the word at p. A bad position, an insert into a full
// list or an unknown operation gives out_status high and changes nothing.
// Each word lives in its own cell; every cell decides in the same cycle
// whether to load, take its left or right neighbour, or hold, so the list
// is updated at the edge that takes the request.
// Exactly one result per request: out_valid is high for one cycle, after the
// request passes the s1 and s2 valid registers, and the receiver cannot stall it.
// A read goes through one registered stage of OR groups of eight cells, then
// a final OR. One request may be taken every cycle that busy is low; busy is
// high during reset and in the cycle after it.
// Reset empties the list; the contents of cells are not cleared.
module positional_list_store #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [pls_pkg::OP_W-1:0]          in_operation,
  input  wire logic [pls_pkg::POS_W-1:0]         in_position,
  input  wire logic signed [pls_pkg::WORD_W-1:0] in_value,
  output logic                                   out_valid,
  output logic [0:0]                             out_status,
  output logic signed [pls_pkg::WORD_W-1:0]      out_read_value
);
  import pls_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned GRP   = 8;
  localparam int unsigned NGRP  = (DEPTH + GRP - 1) / GRP;

  logic             busy_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic             accept;
  op_t              op;
  logic [IDX_W-1:0] pos_ext;
  logic [IDX_W-1:0] cnt_ext;
  logic             pos_nz;
  logic             ins_ok;
  logic             del_ok;
  logic             rd_ok;
  cell_cmd_t        cmd;

  logic             s1_valid_r;
  logic             s1_status_r;
  logic             s1_rd_r;
  logic [IDX_W-1:0] s1_at_r;
  logic             s2_valid_r;
  logic             s2_status_r;

  logic [WORD_W-1:0] ents [DEPTH];
  logic [WORD_W-1:0] grps [NGRP];
  logic [WORD_W-1:0] rd_word;

  assign accept  = start && !busy_r;
  assign op      = op_t'(in_operation);
  assign pos_ext = IDX_W'(in_position);
  assign cnt_ext = IDX_W'(count_r);
  assign pos_nz  = (in_position != '0);

  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    rd_ok  = 1'b0;
    case (op)
      OP_INSERT: begin
        ins_ok = pos_nz && (pos_ext <= cnt_ext + IDX_W'(1)) && (cnt_ext < IDX_W'(DEPTH));
      end
      OP_DELETE: begin
        del_ok = pos_nz && (pos_ext <= cnt_ext);
      end
      OP_READ: begin
        rd_ok = pos_nz && (pos_ext <= cnt_ext);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.ins   = accept && ins_ok;
    cmd.del   = accept && del_ok;
    cmd.at    = pos_ext - IDX_W'(1);
    cmd.cnt   = cnt_ext;
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = ents[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = ents[k+1];
    end
    pls_cell #(.IDX(k)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .value (in_value),
      .left  (left_w),
      .right (right_w),
      .entry (ents[k])
    );
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    localparam int unsigned BASE = g * GRP;
    localparam int unsigned GN   = (DEPTH - BASE < GRP) ? (DEPTH - BASE) : GRP;
    logic [WORD_W-1:0] sub [GN];
    for (genvar i = 0; i < GN; i++) begin : g_tap
      assign sub[i] = ents[BASE + i];
    end
    pls_rd_group #(.N(GN), .BASE(BASE)) u_grp (
      .clk   (clk),
      .ents  (sub),
      .rd_en (s1_rd_r),
      .at    (s1_at_r),
      .grp   (grps[g])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int unsigned g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grps[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      count_r    <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      count_r    <= count_nxt;
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_status_r <= (ins_ok || del_ok || rd_ok) ? STATUS_OK : STATUS_ERR;
    s1_rd_r     <= accept && rd_ok;
    s1_at_r     <= pos_ext - IDX_W'(1);
    s2_status_r <= s1_status_r;
  end

  assign busy           = busy_r;
  assign out_valid      = s2_valid_r;
  assign out_status     = s2_status_r;
  assign out_read_value = $signed(rd_word);

  `ASSERT_ALWAYS(a_count_le_depth, clk, rst_n, count_r <= CNT_W'(DEPTH), "length above depth")
  `ASSERT_IMPLIES(a_result_follows_request, clk, rst_n, out_valid, $past(accept, 2), "result without request")
  `ASSERT_IMPLIES(a_error_reads_zero, clk, rst_n, out_valid && out_status == STATUS_ERR, out_read_value == '0, "error result carries data")

endmodule
`default_nettype wire
